/* rtl/mms_pkg.sv */
// Shared constants, types, weight ROMs and tanh table for the move selector.
package mms_pkg;

  localparam int FRAC_BITS = 14;
  localparam int DIST_W    = 14;
  localparam int SIDE_W    = 15;
  localparam int MOVE_W    = 3;
  localparam int SCORE_W   = 16;
  localparam int N_IN      = 3;
  localparam int N_OUT     = 5;
  localparam int ROM_HID   = 16;

  localparam int WGT_W   = FRAC_BITS + 4;
  localparam int X_W     = FRAC_BITS + 3;
  localparam int ACT_W   = FRAC_BITS + 2;
  localparam int PROD_W  = WGT_W + X_W;
  localparam int ACC_W   = PROD_W + 5;
  localparam int RS_W    = ACC_W - FRAC_BITS;
  localparam int DIV_W   = DIST_W + FRAC_BITS;
  localparam int SEG_SH  = FRAC_BITS - 3;
  localparam int TANH_W  = 17;
  localparam int T_SH    = 16 - FRAC_BITS;
  localparam int Q14_SH  = FRAC_BITS - 14;

  localparam int ACC_HALF  = (1 << FRAC_BITS) >> 1;
  localparam int SEG_HALF  = (1 << SEG_SH) >> 1;
  localparam int T_HALF    = (1 << T_SH) >> 1;
  localparam int Q14_HALF  = (1 << Q14_SH) >> 1;

  localparam int DEF_HISTORY_DEPTH = 5;
  localparam int DEF_HIDDEN_COUNT  = 4;

  localparam logic [DIST_W-1:0] FSD_RESET  = DIST_W'(50);
  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(13107);
  localparam logic signed [SCORE_W-1:0] SCORE_NONE = SCORE_W'(-16384);

  localparam longint unsigned DecOne = 64'd10000000000;

  // register indexes on the APB port (byte address bit 2)
  localparam logic REG_FSD  = 1'b0;
  localparam logic REG_SIDE = 1'b1;

  // network input rows
  localparam logic [1:0] IN_BIAS = 2'd0;
  localparam logic [1:0] IN_NEAR = 2'd1;
  localparam logic [1:0] IN_SIDE = 2'd2;

  typedef enum logic [MOVE_W-1:0] {
    MOVE_FORWARD = 3'd0,
    MOVE_LEFT    = 3'd1,
    MOVE_RIGHT   = 3'd2,
    MOVE_REVERSE = 3'd3,
    MOVE_TURN    = 3'd4
  } move_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_MAC,
    ST_TAIL,
    ST_RND,
    ST_SEG,
    ST_TMUL,
    ST_TOUT,
    ST_SEL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic  wr;
    move_t wr_move;
    move_t query;
  } hist_req_t;

  // round(d * 2^FRAC_BITS / 1e10), halves away from zero
  function automatic logic signed [WGT_W-1:0] dec_to_fix(input longint d);
    longint unsigned m;
    longint unsigned q;
    logic signed [WGT_W-1:0] r;
    m = (d < 0) ? longint'(-d) : longint'(d);
    q = (m * (64'd1 << FRAC_BITS) + DecOne / 2) / DecOne;
    r = q[WGT_W-1:0];
    return (d < 0) ? -r : r;
  endfunction

  // input row x hidden unit; units past the fourth have zero weights
  function automatic logic signed [WGT_W-1:0] hid_weight(input logic [1:0] j,
                                                         input logic [3:0] i);
    logic signed [WGT_W-1:0] w;
    case ({j, i})
      {2'd0, 4'd0}: w = dec_to_fix(64'sd18991509504);
      {2'd0, 4'd1}: w = dec_to_fix(-64'sd4769472541);
      {2'd0, 4'd2}: w = dec_to_fix(-64'sd6483690221);
      {2'd0, 4'd3}: w = dec_to_fix(-64'sd3860916525);
      {2'd1, 4'd0}: w = dec_to_fix(-64'sd2818610915);
      {2'd1, 4'd1}: w = dec_to_fix(64'sd40106956995);
      {2'd1, 4'd2}: w = dec_to_fix(64'sd32291858058);
      {2'd1, 4'd3}: w = dec_to_fix(-64'sd28943011047);
      {2'd2, 4'd0}: w = dec_to_fix(64'sd3340650865);
      {2'd2, 4'd1}: w = dec_to_fix(-64'sd14016114422);
      {2'd2, 4'd2}: w = dec_to_fix(64'sd13580053903);
      {2'd2, 4'd3}: w = dec_to_fix(-64'sd9814159763);
      default:      w = '0;
    endcase
    return w;
  endfunction

  // hidden unit x output move
  function automatic logic signed [WGT_W-1:0] out_weight(input logic [3:0] j,
                                                         input logic [2:0] o);
    logic signed [WGT_W-1:0] w;
    case ({j, o})
      {4'd0, 3'd0}: w = dec_to_fix(64'sd11360722975);
      {4'd0, 3'd1}: w = dec_to_fix(64'sd15460239494);
      {4'd0, 3'd2}: w = dec_to_fix(64'sd16194612260);
      {4'd0, 3'd3}: w = dec_to_fix(64'sd18819066697);
      {4'd0, 3'd4}: w = dec_to_fix(64'sd1000000000);
      {4'd1, 3'd0}: w = dec_to_fix(-64'sd15469665068);
      {4'd1, 3'd1}: w = dec_to_fix(64'sd13951930739);
      {4'd1, 3'd2}: w = dec_to_fix(64'sd1939382609);
      {4'd1, 3'd3}: w = dec_to_fix(64'sd3099250414);
      {4'd1, 3'd4}: w = dec_to_fix(64'sd2000000000);
      {4'd2, 3'd0}: w = dec_to_fix(-64'sd7755982418);
      {4'd2, 3'd1}: w = dec_to_fix(64'sd9390808626);
      {4'd2, 3'd2}: w = dec_to_fix(64'sd20862510746);
      {4'd2, 3'd3}: w = dec_to_fix(-64'sd11229484266);
      {4'd2, 3'd4}: w = dec_to_fix(64'sd2000000000);
      {4'd3, 3'd0}: w = dec_to_fix(-64'sd12357090352);
      {4'd3, 3'd1}: w = dec_to_fix(64'sd8583930286);
      {4'd3, 3'd2}: w = dec_to_fix(64'sd7247020799);
      {4'd3, 3'd3}: w = dec_to_fix(64'sd9762852710);
      {4'd3, 3'd4}: w = dec_to_fix(64'sd1000000000);
      default:      w = '0;
    endcase
    return w;
  endfunction

  // tanh(k/8) in Q.16
  function automatic logic [15:0] tanh_tab(input logic [5:0] k);
    logic [15:0] v;
    case (k)
      6'd0:  v = 16'd0;
      6'd1:  v = 16'd8150;
      6'd2:  v = 16'd16051;
      6'd3:  v = 16'd23485;
      6'd4:  v = 16'd30285;
      6'd5:  v = 16'd36346;
      6'd6:  v = 16'd41625;
      6'd7:  v = 16'd46131;
      6'd8:  v = 16'd49912;
      6'd9:  v = 16'd53038;
      6'd10: v = 16'd55593;
      6'd11: v = 16'd57660;
      6'd12: v = 16'd59320;
      6'd13: v = 16'd60643;
      6'd14: v = 16'd61694;
      6'd15: v = 16'd62524;
      6'd16: v = 16'd63179;
      6'd17: v = 16'd63693;
      6'd18: v = 16'd64096;
      6'd19: v = 16'd64412;
      6'd20: v = 16'd64659;
      6'd21: v = 16'd64852;
      6'd22: v = 16'd65003;
      6'd23: v = 16'd65120;
      6'd24: v = 16'd65212;
      6'd25: v = 16'd65283;
      6'd26: v = 16'd65339;
      6'd27: v = 16'd65383;
      6'd28: v = 16'd65417;
      6'd29: v = 16'd65443;
      6'd30: v = 16'd65464;
      6'd31: v = 16'd65480;
      6'd32: v = 16'd65492;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/mms_history.sv */
// Ring of recently emitted moves with a membership check.
module mms_history #(
  parameter int HISTORY_DEPTH = mms_pkg::DEF_HISTORY_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  mms_pkg::hist_req_t req,
  output logic              hit
);
  import mms_pkg::*;

  localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  move_t            recent [HISTORY_DEPTH];
  logic [PTR_W-1:0] ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        recent[i] <= MOVE_FORWARD;
      end
      ptr <= '0;
    end else if (req.wr) begin
      recent[ptr] <= req.wr_move;
      if (ptr == PTR_W'(HISTORY_DEPTH - 1)) begin
        ptr <= '0;
      end else begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (recent[i] == req.query) begin
        hit = 1'b1;
      end
    end
  end

endmodule

/* rtl/mlp_move_selector_with_history.sv */
// Top level: obstacle move selector with a 3-4-5 tanh network and move history.
//
//  channel | dir | handshake               | contents
//  s_*     | in  | s_tvalid / s_tready     | tdata: left, right clearance; tuser: mode
//  m_*     | out | m_tvalid / m_tready     | tdata: move, winning_score; tuser: no_fresh_move
//  apb     | in  | psel, penable, pready=1 | 0x0 full_scale_distance, 0x4 side_input_magnitude
//
// A clear-path beat goes straight from idle to the done state. A blocked beat
// runs the divider, then one shared multiplier stepping through every product
// and the tanh slope. Reset (rst, synchronous) loads 50 and 13107 into the
// registers and fills the history with forward. The result waits in an output
// register; the next beat is taken meanwhile and holds at its end until that
// register is free.
module mlp_move_selector_with_history #(
  parameter int HISTORY_DEPTH = mms_pkg::DEF_HISTORY_DEPTH,
  parameter int HIDDEN_COUNT  = mms_pkg::DEF_HIDDEN_COUNT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [13:0] left_clearance, [27:14] right_clearance
  input  logic        s_tuser,   // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [2:0] move, [18:3] winning_score
  output logic        m_tuser,   // [0] no_fresh_move
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mms_pkg::*;

  localparam int CNT_MAX   = (HIDDEN_COUNT > N_OUT) ? HIDDEN_COUNT : N_OUT;
  localparam int CNT_W     = $clog2(CNT_MAX);
  localparam int HID_IDX_W = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
  localparam int OUT_IDX_W = $clog2(N_OUT);
  localparam int DIVK_W    = $clog2(FRAC_BITS + 1);

  localparam logic signed [X_W-1:0]   X_ONE   = X_W'(1 << FRAC_BITS);
  localparam logic signed [ACT_W-1:0] ACT_ONE = ACT_W'(1 << FRAC_BITS);

  state_t state, state_next;

  logic [DIST_W-1:0] fsd;
  logic [SIDE_W-1:0] side_mag;

  logic                  clear_item;
  logic                  side_neg;
  logic                  near_zero;
  logic [DIV_W-1:0]      rem;
  logic [FRAC_BITS:0]    quot;
  logic [DIVK_W-1:0]     div_k;

  logic                  layer;
  logic [CNT_W-1:0]      unit;
  logic [CNT_W-1:0]      jcnt;
  logic [CNT_W-1:0]      j_last;
  logic [CNT_W-1:0]      unit_last;

  logic signed [WGT_W-1:0]  mul_a;
  logic signed [X_W-1:0]    mul_b;
  logic signed [X_W-1:0]    x_sel;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [RS_W-1:0]   rsum;
  logic [RS_W-1:0]          mag;
  logic [4:0]               seg_idx;

  logic [15:0]        t_tab0;
  logic [15:0]        t_d;
  logic [SEG_SH-1:0]  t_frac;
  logic               t_sat;
  logic               t_neg;

  logic signed [PROD_W-1:0] tm;
  logic [TANH_W-1:0]        y16;
  logic [TANH_W-1:0]        y16r;
  logic signed [ACT_W-1:0]  act_mag;
  logic signed [ACT_W-1:0]  act;

  logic signed [ACT_W-1:0] hidden [HIDDEN_COUNT];
  logic signed [ACT_W-1:0] scores [N_OUT];

  logic signed [ACT_W-1:0] best;
  logic signed [ACT_W-1:0] best_r;
  move_t                   best_mv;
  logic                    found;

  move_t                     out_move;
  logic signed [SCORE_W-1:0] out_score;
  logic                      out_nf;

  logic              in_accept;
  logic              load_out;
  logic [DIST_W-1:0] in_left;
  logic [DIST_W-1:0] in_right;
  logic [DIST_W-1:0] maxd;
  logic              left_gt;
  logic [DIV_W-1:0]  div_cand;

  hist_req_t hist_req;
  logic      hist_hit;

  assign in_left   = s_tdata[DIST_W-1:0];
  assign in_right  = s_tdata[2*DIST_W-1:DIST_W];
  assign left_gt   = in_left > in_right;
  assign maxd      = left_gt ? in_left : in_right;
  assign in_accept = s_tvalid && s_tready;
  assign s_tready  = (state == ST_IDLE);
  assign load_out  = (state == ST_DONE) && (!m_tvalid || m_tready);
  assign j_last    = layer ? CNT_W'(HIDDEN_COUNT - 1) : CNT_W'(N_IN - 1);
  assign unit_last = layer ? CNT_W'(N_OUT - 1) : CNT_W'(HIDDEN_COUNT - 1);
  assign div_cand  = DIV_W'(fsd) << div_k;

  assign pready  = 1'b1;
  assign m_tdata = {5'b0, out_score, out_move};
  assign m_tuser = out_nf;

  always_comb begin
    case (paddr[2])
      REG_FSD:  prdata = 32'(fsd);
      REG_SIDE: prdata = 32'(side_mag);
      default:  prdata = '0;
    endcase
  end

  // network input for the current row
  always_comb begin
    case (jcnt[1:0])
      IN_BIAS: x_sel = X_ONE;
      IN_NEAR: x_sel = near_zero ? '0 : X_W'(quot);
      IN_SIDE: x_sel = side_neg ? -(X_W'(side_mag) << Q14_SH) : (X_W'(side_mag) << Q14_SH);
      default: x_sel = '0;
    endcase
  end

  // operands of the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MAC: begin
        if (!layer) begin
          mul_a = hid_weight(jcnt[1:0], 4'(unit));
          mul_b = x_sel;
        end else begin
          mul_a = out_weight(4'(jcnt), unit[OUT_IDX_W-1:0]);
          mul_b = X_W'(hidden[jcnt[HID_IDX_W-1:0]]);
        end
      end
      ST_TMUL: begin
        mul_a = WGT_W'(t_d);
        mul_b = X_W'(t_frac);
      end
      default: ;
    endcase
  end

  // rounding, tanh segment and interpolation arithmetic
  always_comb begin
    acc_r   = acc + ACC_W'(ACC_HALF);
    mag     = rsum[RS_W-1] ? RS_W'(-rsum) : RS_W'(rsum);
    seg_idx = mag[SEG_SH+4:SEG_SH];
    tm      = prod + PROD_W'(SEG_HALF);
    y16     = t_sat ? TANH_W'(tanh_tab(6'd32))
                    : TANH_W'(t_tab0) + TANH_W'(tm[SEG_SH+15:SEG_SH]);
    y16r    = y16 + TANH_W'(T_HALF);
    act_mag = ACT_W'(y16r[TANH_W-1:T_SH]);
    act     = t_neg ? -act_mag : act_mag;
    best_r  = best + ACT_W'(Q14_HALF);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_accept) state_next = s_tuser ? ST_DIV : ST_DONE;
      ST_DIV:  if (div_k == '0) state_next = ST_MAC;
      ST_MAC:  if (jcnt == j_last) state_next = ST_TAIL;
      ST_TAIL: state_next = ST_RND;
      ST_RND:  state_next = ST_SEG;
      ST_SEG:  state_next = ST_TMUL;
      ST_TMUL: state_next = ST_TOUT;
      ST_TOUT: state_next = (layer && unit == unit_last) ? ST_SEL : ST_MAC;
      ST_SEL:  if (unit == CNT_W'(N_OUT - 1)) state_next = ST_DONE;
      ST_DONE: if (!m_tvalid || m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      fsd      <= FSD_RESET;
      side_mag <= SIDE_RESET;
    end else begin
      state <= state_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_FSD:  fsd      <= pwdata[DIST_W-1:0];
          REG_SIDE: side_mag <= pwdata[SIDE_W-1:0];
          default:  ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_accept) begin
          clear_item <= !s_tuser;
          side_neg   <= !left_gt;
          near_zero  <= (fsd == '0) || (maxd >= fsd);
          rem        <= (DIV_W'(fsd - maxd) << FRAC_BITS) + DIV_W'(fsd >> 1);
          quot       <= '0;
          div_k      <= DIVK_W'(FRAC_BITS);
          layer      <= 1'b0;
          unit       <= '0;
          jcnt       <= '0;
        end
      end
      ST_DIV: begin
        if (rem >= div_cand) begin
          rem         <= rem - div_cand;
          quot[div_k] <= 1'b1;
        end
        div_k <= div_k - 1'b1;
      end
      ST_MAC: begin
        prod <= PROD_W'(mul_a * mul_b);
        acc  <= (jcnt == '0) ? '0 : acc + ACC_W'(prod);
        jcnt <= (jcnt == j_last) ? '0 : jcnt + 1'b1;
      end
      ST_TAIL: begin
        acc <= acc + ACC_W'(prod);
      end
      ST_RND: begin
        rsum <= acc_r[ACC_W-1:FRAC_BITS];
      end
      ST_SEG: begin
        t_neg  <= rsum[RS_W-1];
        t_sat  <= |mag[RS_W-1:SEG_SH+5];
        t_frac <= mag[SEG_SH-1:0];
        t_tab0 <= tanh_tab({1'b0, seg_idx});
        t_d    <= tanh_tab({1'b0, seg_idx} + 6'd1) - tanh_tab({1'b0, seg_idx});
      end
      ST_TMUL: begin
        prod <= PROD_W'(mul_a * mul_b);
      end
      ST_TOUT: begin
        if (!layer) begin
          hidden[unit[HID_IDX_W-1:0]] <= act;
        end else begin
          scores[unit[OUT_IDX_W-1:0]] <= act;
        end
        if (unit == unit_last) begin
          unit    <= '0;
          layer   <= 1'b1;
          best    <= -ACT_ONE;
          best_mv <= MOVE_FORWARD;
          found   <= 1'b0;
        end else begin
          unit <= unit + 1'b1;
        end
      end
      ST_SEL: begin
        // keep the first highest score whose move is not in the history
        if (scores[unit[OUT_IDX_W-1:0]] > best && !hist_hit) begin
          best    <= scores[unit[OUT_IDX_W-1:0]];
          best_mv <= move_t'(unit[MOVE_W-1:0]);
          found   <= 1'b1;
        end
        unit <= unit + 1'b1;
      end
      ST_DONE: begin
        if (load_out) begin
          if (clear_item) begin
            out_move  <= MOVE_FORWARD;
            out_score <= '0;
            out_nf    <= 1'b0;
          end else begin
            out_move  <= best_mv;
            out_score <= found ? SCORE_W'(best_r >>> Q14_SH) : SCORE_NONE;
            out_nf    <= !found;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    hist_req.wr      = load_out;
    hist_req.wr_move = clear_item ? MOVE_FORWARD : best_mv;
    hist_req.query   = move_t'(unit[MOVE_W-1:0]);
  end

  mms_history #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk (clk),
    .rst (rst),
    .req (hist_req),
    .hit (hist_hit)
  );

endmodule

/* rtl/mms_checker.sv */
// Port-level assertions for the move selector, bound to the top level.
module mms_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic        m_tuser
);

  localparam logic [15:0] NONE_SCORE = 16'hC000;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // one beat at a time: input closes right after a beat is taken
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input ready right after an accepted beat");

  // defaulted result carries forward and the empty score
  a_default: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[2:0] == 3'd0 && m_tdata[18:3] == NONE_SCORE)
    else $error("defaulted result with wrong move or score");

  // a chosen move is a real move with a score other than the empty score and zero upper bits
  a_chosen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[2:0] <= 3'd4 && m_tdata[18:3] != NONE_SCORE
                             && m_tdata[23:19] == 5'd0)
    else $error("chosen result out of range");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

endmodule

bind mlp_move_selector_with_history mms_checker u_mms_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Testbench for the move selector: directed events, then random events over several settings.
module testbench;
  import mms_pkg::*;

  localparam int HIST_N       = DEF_HISTORY_DEPTH;
  localparam int HID_N        = DEF_HIDDEN_COUNT;
  localparam int N_DIRECTED   = 20;
  localparam int N_PHASES     = 8;
  localparam int PHASE_EVENTS = 240;
  localparam int STALL_LIMIT  = 3000;
  localparam int TAIL_CYCLES  = 120;

  typedef struct packed {
    logic        mode;
    logic [13:0] left;
    logic [13:0] right;
  } event_t;

  typedef struct packed {
    move_t              move;
    logic signed [15:0] score;
    logic               defaulted;
  } move_result_t;

  localparam move_result_t CLEAR_RESULT = '{MOVE_FORWARD, 16'sd0, 1'b0};

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;    // [13:0] left_clearance, [27:14] right_clearance
  logic        s_tuser  = 1'b0;  // [0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;          // [2:0] move, [18:3] winning_score
  logic        m_tuser;          // [0] no_fresh_move
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  mlp_move_selector_with_history dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // network weights as exact decimals in units of 1e-10
  longint hid_dec [3][4] = '{
    '{ 64'sd18991509504,  -64'sd4769472541,  -64'sd6483690221,  -64'sd3860916525},
    '{ -64'sd2818610915,  64'sd40106956995,  64'sd32291858058, -64'sd28943011047},
    '{  64'sd3340650865, -64'sd14016114422,  64'sd13580053903,  -64'sd9814159763}
  };
  longint out_dec [4][5] = '{
    '{ 64'sd11360722975, 64'sd15460239494, 64'sd16194612260,  64'sd18819066697,
       64'sd1000000000},
    '{-64'sd15469665068, 64'sd13951930739,  64'sd1939382609,   64'sd3099250414,
       64'sd2000000000},
    '{ -64'sd7755982418,  64'sd9390808626, 64'sd20862510746, -64'sd11229484266,
       64'sd2000000000},
    '{-64'sd12357090352,  64'sd8583930286,  64'sd7247020799,   64'sd9762852710,
       64'sd1000000000}
  };
  // tanh(k/8) in Q.16
  int tanh_q16 [33] = '{
    0, 8150, 16051, 23485, 30285, 36346, 41625, 46131,
    49912, 53038, 55593, 57660, 59320, 60643, 61694, 62524,
    63179, 63693, 64096, 64412, 64659, 64852, 65003, 65120,
    65212, 65283, 65339, 65383, 65417, 65443, 65464, 65480,
    65492
  };

  event_t dir_events [N_DIRECTED] = '{
    '{1'b0, 14'd0,     14'd0},
    '{1'b1, 14'd0,     14'd0},
    '{1'b1, 14'd9999,  14'd0},
    '{1'b1, 14'd0,     14'd9999},
    '{1'b0, 14'd16383, 14'd16383},
    '{1'b1, 14'd10,    14'd40},
    '{1'b1, 14'd49,    14'd49},
    '{1'b1, 14'd50,    14'd20},
    '{1'b1, 14'd16383, 14'd16383},
    '{1'b1, 14'd1,     14'd0},
    '{1'b1, 14'd5,     14'd5},
    '{1'b1, 14'd30,    14'd2},
    '{1'b1, 14'd2,     14'd30},
    '{1'b1, 14'd12,    14'd12},
    '{1'b1, 14'd25,    14'd3},
    '{1'b1, 14'd0,     14'd1},
    '{1'b0, 14'd9999,  14'd9999},
    '{1'b1, 14'd8191,  14'd8192},
    '{1'b1, 14'd10922, 14'd5461},
    '{1'b0, 14'd0,     14'd0}
  };
  int fsd_set  [5] = '{1, 9999, 0, 16383, 50};
  int side_set [5] = '{0, 16384, 32767, 1, 8000};

  // predictor state
  logic [13:0]  fsd_cfg  = FSD_RESET;
  logic [14:0]  side_cfg = SIDE_RESET;
  move_t        move_hist [HIST_N];
  int           hist_ptr = 0;
  move_result_t pending_moves [$];

  int mismatches     = 0;
  int events_sent    = 0;
  int blocked_sent   = 0;
  int results_seen   = 0;
  int defaulted_seen = 0;
  int settings_used  = 1;
  int burst_left     = 0;
  int idle_cycles    = 0;
  int cycle_n        = 0;
  move_result_t got, want;

  // round half away from zero to Q.FRAC_BITS
  function automatic longint weight_fix(longint d);
    longint m, q;
    m = (d < 0) ? -d : d;
    q = (m * (64'sd1 <<< FRAC_BITS) + 64'sd5000000000) / 64'sd10000000000;
    return (d < 0) ? -q : q;
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint squash(longint v);
    longint a, seg, slope, y;
    a   = (v < 0) ? -v : v;
    seg = a >>> (FRAC_BITS - 3);
    if (seg >= 32) begin
      y = tanh_q16[32];
    end else begin
      slope = tanh_q16[seg + 1] - tanh_q16[seg];
      y = tanh_q16[seg] +
          round_shift(slope * (a & ((64'sd1 <<< (FRAC_BITS - 3)) - 1)), FRAC_BITS - 3);
    end
    y = round_shift(y, 16 - FRAC_BITS);
    return (v < 0) ? -y : y;
  endfunction

  function automatic void log_move(move_t mv);
    move_hist[hist_ptr] = mv;
    hist_ptr = (hist_ptr + 1) % HIST_N;
  endfunction

  function automatic move_result_t choose_move(event_t ev);
    longint x [3];
    longint hid [HID_N];
    longint score [5];
    longint acc, best, maxd, fsd, side;
    bit found, seen;
    int pick;
    move_result_t res;
    if (!ev.mode) begin
      log_move(MOVE_FORWARD);
      return CLEAR_RESULT;
    end
    fsd  = fsd_cfg;
    side = side_cfg;
    maxd = (ev.left > ev.right) ? ev.left : ev.right;
    x[0] = 64'sd1 <<< FRAC_BITS;
    if (fsd == 0 || maxd >= fsd) x[1] = 0;
    else x[1] = (((fsd - maxd) <<< FRAC_BITS) + fsd / 2) / fsd;
    // equal clearances count as the right side being freer
    x[2] = (ev.left > ev.right) ? side : -side;
    for (int i = 0; i < HID_N; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += weight_fix(hid_dec[j][i]) * x[j];
      hid[i] = squash(round_shift(acc, FRAC_BITS));
    end
    for (int i = 0; i < 5; i++) begin
      acc = 0;
      for (int j = 0; j < HID_N; j++) acc += weight_fix(out_dec[j][i]) * hid[j];
      score[i] = squash(round_shift(acc, FRAC_BITS));
    end
    best  = -(64'sd1 <<< FRAC_BITS);
    found = 1'b0;
    pick  = 0;
    for (int i = 0; i < 5; i++) begin
      seen = 1'b0;
      for (int k = 0; k < HIST_N; k++) if (move_hist[k] == i) seen = 1'b1;
      if (score[i] > best && !seen) begin
        best  = score[i];
        pick  = i;
        found = 1'b1;
      end
    end
    log_move(move_t'(pick));
    res.move      = move_t'(pick);
    res.score     = found ? best[15:0] : SCORE_NONE;
    res.defaulted = !found;
    return res;
  endfunction

  function automatic event_t rand_event();
    event_t ev;
    int pick, span;
    ev.mode = ($urandom_range(0, 9) >= 2);
    pick = $urandom_range(0, 9);
    // mostly clearances around the full-scale distance, where nearness varies
    span = (pick < 7) ? 2 * int'(fsd_cfg) + 1 : (pick < 9) ? 9999 : 16383;
    if (span > 16383) span = 16383;
    ev.left  = 14'($urandom_range(0, span));
    ev.right = ($urandom_range(0, 9) == 0) ? ev.left : 14'($urandom_range(0, span));
    return ev;
  endfunction

  task automatic send_event(event_t ev, bit typed, move_result_t typed_result);
    move_result_t exp_result;
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, ev.right, ev.left};
    s_tuser  <= ev.mode;
    do @(posedge clk); while (!s_tready);
    exp_result = choose_move(ev);
    if (typed) exp_result = typed_result;
    pending_moves.push_back(exp_result);
    events_sent++;
    if (ev.mode) blocked_sent++;
  endtask

  task automatic pause_sender(int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_moves.size() != 0);
  endtask

  task automatic next_event(event_t ev);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 120));
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    send_event(ev, 1'b0, CLEAR_RESULT);
  endtask

  task automatic reg_write(logic reg_sel, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (reg_sel == REG_FSD) fsd_cfg = value[13:0];
    else side_cfg = value[14:0];
  endtask

  // receiver: cycle through always ready, coin flip, rare and periodic ready
  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    case (cycle_n[9:8])
      2'd0: m_tready <= 1'b1;
      2'd1: m_tready <= 1'($urandom_range(0, 1));
      2'd2: m_tready <= (cycle_n[3:0] == 4'd0);
      default: m_tready <= cycle_n[2];
    endcase
    if (!rst && m_tvalid && m_tready) begin
      got.move      = move_t'(m_tdata[2:0]);
      got.score     = m_tdata[18:3];
      got.defaulted = m_tuser;
      if (pending_moves.size() == 0) begin
        $display("%0t: unexpected beat, move %0d score %0d flag %0d",
                 $time, got.move, got.score, got.defaulted);
        mismatches++;
      end else begin
        want = pending_moves.pop_front();
        results_seen++;
        if (got.defaulted) defaulted_seen++;
        if (got.move != want.move) begin
          $display("%0t: move expected %0d actual %0d", $time, want.move, got.move);
          mismatches++;
        end
        if (got.score != want.score) begin
          $display("%0t: winning_score expected %0d actual %0d", $time, want.score,
                   got.score);
          mismatches++;
        end
        if (got.defaulted != want.defaulted) begin
          $display("%0t: no_fresh_move expected %0d actual %0d", $time, want.defaulted,
                   got.defaulted);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on any port
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, idle_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    for (int k = 0; k < HIST_N; k++) move_hist[k] = MOVE_FORWARD;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings; clear-path rows carry their known result
    for (int i = 0; i < N_DIRECTED; i++)
      send_event(dir_events[i], !dir_events[i].mode, CLEAR_RESULT);

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      if (p < 5) begin
        reg_write(REG_FSD, fsd_set[p]);
        reg_write(REG_SIDE, side_set[p]);
      end else begin
        reg_write(REG_FSD, $urandom_range(1, 400));
        reg_write(REG_SIDE, $urandom_range(0, 16384));
      end
      settings_used++;
      burst_left = 0;
      for (int n = 0; n < PHASE_EVENTS; n++) begin
        // hold the sender until the pipeline is empty once per phase
        if (n == PHASE_EVENTS / 2) drain();
        next_event(rand_event());
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d events (%0d blocked) over %0d register settings;",
             events_sent, blocked_sent, settings_used);
    $display("checked %0d results, %0d of them defaulting to forward.",
             results_seen, defaulted_seen);
    if (mismatches == 0 && pending_moves.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_moves.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
